// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define BMM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BMM_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define BMM_ASSERT(lbl, clk, rstn, prop, msg)
`define BMM_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- src/bmm_pkg.sv -----
`default_nettype none

package bmm_pkg;

  // Matrix limits, fixed by the widths of the stream fields.
  localparam int MAX_LEFT  = 16;
  localparam int MAX_RIGHT = 16;

  localparam int ROW_W   = 16;                  // one adjacency row
  localparam int COL_W   = $clog2(MAX_RIGHT);   // right vertex index
  localparam int LIDX_W  = $clog2(MAX_LEFT);    // left row index
  localparam int CNT_W   = 5;                   // counts and 1-based vertex numbers
  localparam int OUT_W   = 16;                  // packed result word

  // One search frame: left vertex, next column to examine, chosen column.
  typedef struct packed {
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] next;
    logic [COL_W-1:0] col;
  } frame_t;

  // Result of the candidate column search.
  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] col;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- src/bmm_scan.sv -----
`default_nettype none

// Finds the lowest column at or above the start column that has an edge,
// is not yet visited and lies below the right count.
module bmm_scan import bmm_pkg::*; (
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [ROW_W-1:0] visited,
  input  wire logic [CNT_W-1:0] start,
  input  wire logic [CNT_W-1:0] limit,
  output scan_res_t             res
);

  logic [ROW_W-1:0] cand;

  // Candidate mask, one bit per column.
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      cand[i] = row[i] && !visited[i] &&
                (CNT_W'(i) >= start) && (CNT_W'(i) < limit);
    end
  end

  // Lowest set bit wins.
  always_comb begin
    res.found = 1'b0;
    res.col   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found = 1'b1;
        res.col   = COL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/bmm_stack.sv -----
`default_nettype none

// Depth-first search stack: one write port, one registered read port.
module bmm_stack import bmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [LIDX_W-1:0] wr_addr,
  input  wire frame_t            wr_data,
  input  wire logic [LIDX_W-1:0] rd_addr,
  output frame_t                 rd_data
);

  frame_t mem [MAX_LEFT];

  // Write frame on push.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is registered: it appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/bipartite_max_matching_unit.sv -----
// Loading stores one row per transfer; a row without the last mark returns nothing.
// Matching per left vertex: a set-up and a wrap-up step, a scan of the top frame, an extra
// pop step per pop of the stack, and a write-back of the stacked frames of a path.
// Results follow at one per cycle while out_tready is high; no row is taken meanwhile.
// Synchronous active-low reset: no rows loaded, right count 16, all unmatched.
`default_nettype none

`include "assert_macros.svh"

module bipartite_max_matching_unit import bmm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Configuration: right_count
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data,
  // Input rows
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [ROW_W-1:0] in_tdata,   // [15:0] row_bits
  input  wire logic             in_tlast,   // last_row
  // Results
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [3:0] right_index, [8:4] matched_left,
                                            // [13:9] match_total, [15:14] zero
  output logic                  out_tlast   // last
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POPW  = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [CNT_W-1:0] LEFT_MAX_C  = CNT_W'(MAX_LEFT);
  localparam logic [CNT_W-1:0] RIGHT_MAX_C = CNT_W'(MAX_RIGHT);

  logic [2:0]        state_r, state_nxt;
  logic [ROW_W-1:0]  adj_r [MAX_LEFT];
  logic [CNT_W-1:0]  partner_r [MAX_RIGHT];
  logic [CNT_W-1:0]  rows_loaded_r;
  logic [CNT_W-1:0]  cfg_rc_r;
  logic [CNT_W-1:0]  rc_r;
  logic [CNT_W-1:0]  left_total_r;
  logic [CNT_W-1:0]  u_r;
  logic [CNT_W-1:0]  cur_left_r;
  logic [CNT_W-1:0]  cur_next_r;
  logic [CNT_W-1:0]  depth_r;
  logic [ROW_W-1:0]  visited_r;
  logic [LIDX_W-1:0] wb_k_r;
  logic [CNT_W-1:0]  match_cnt_r;
  logic [COL_W-1:0]  oidx_r;

  logic              in_fire, out_fire, out_is_last;
  logic [CNT_W-1:0]  rc_sat, rows_after;
  logic [CNT_W-1:0]  left_m1, depth_m1, depth_m2;
  logic [LIDX_W-1:0] wb_k_m1;
  logic [ROW_W-1:0]  cur_row;
  logic [CNT_W-1:0]  cand_partner;
  scan_res_t         scan;
  logic              stk_we;
  logic [LIDX_W-1:0] stk_waddr, stk_raddr;
  frame_t            stk_wdata, stk_rdata;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;

  assign rc_sat     = (cfg_rc_r > RIGHT_MAX_C) ? RIGHT_MAX_C : cfg_rc_r;
  assign rows_after = (rows_loaded_r < LEFT_MAX_C) ? rows_loaded_r + CNT_W'(1) : rows_loaded_r;

  assign left_m1  = cur_left_r - CNT_W'(1);
  assign depth_m1 = depth_r - CNT_W'(1);
  assign depth_m2 = depth_r - CNT_W'(2);
  assign wb_k_m1  = wb_k_r - LIDX_W'(1);

  assign cur_row      = adj_r[left_m1[LIDX_W-1:0]];
  assign cand_partner = partner_r[scan.col];

  // Shared column search for the frame on top of the stack.
  bmm_scan u_scan (
    .row     (cur_row),
    .visited (visited_r),
    .start   (cur_next_r),
    .limit   (rc_r),
    .res     (scan)
  );

  // Stack port control: push on a matched candidate, read on pop or commit.
  always_comb begin
    stk_we    = (state_r == S_SCAN) && scan.found && (cand_partner != '0);
    stk_waddr = depth_m1[LIDX_W-1:0];
    stk_wdata.left = cur_left_r;
    stk_wdata.next = {1'b0, scan.col} + CNT_W'(1);
    stk_wdata.col  = scan.col;
    case (state_r)
      S_SCAN:  stk_raddr = depth_m2[LIDX_W-1:0];
      S_WB:    stk_raddr = wb_k_m1;
      default: stk_raddr = '0;
    endcase
  end

  bmm_stack u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_fire && in_tlast) begin
          state_nxt = (rc_sat == '0) ? S_LOAD : S_START;
        end
      end
      S_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (!scan.found) begin
          state_nxt = (depth_r == CNT_W'(1)) ? S_NEXT : S_POPW;
        end else if (cand_partner == '0) begin
          state_nxt = (depth_r == CNT_W'(1)) ? S_NEXT : S_WB;
        end
      end
      S_POPW: state_nxt = S_SCAN;
      S_WB: begin
        if (wb_k_r == '0) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: state_nxt = (u_r == left_total_r) ? S_OUT : S_START;
      S_OUT: begin
        if (out_fire && out_is_last) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Adjacency rows are stored as they transfer.
  always_ff @(posedge clk) begin
    if (in_fire && (rows_loaded_r < LEFT_MAX_C)) begin
      adj_r[rows_loaded_r[LIDX_W-1:0]] <= in_tdata;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      rows_loaded_r <= '0;
      cfg_rc_r      <= RIGHT_MAX_C;
      rc_r          <= '0;
      visited_r     <= '0;
      depth_r       <= '0;
      match_cnt_r   <= '0;
      oidx_r        <= '0;
      for (int j = 0; j < MAX_RIGHT; j++) begin
        partner_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_rc_r <= cfg_data;
      end
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (in_tlast) begin
              rows_loaded_r <= '0;
              rc_r          <= rc_sat;
              left_total_r  <= rows_after;
              match_cnt_r   <= '0;
              u_r           <= CNT_W'(1);
              for (int j = 0; j < MAX_RIGHT; j++) begin
                partner_r[j] <= '0;
              end
            end else begin
              rows_loaded_r <= rows_after;
            end
          end
        end
        S_START: begin
          visited_r  <= '0;
          cur_left_r <= u_r;
          cur_next_r <= '0;
          depth_r    <= CNT_W'(1);
        end
        S_SCAN: begin
          if (!scan.found) begin
            // Backtrack to the frame below.
            depth_r <= depth_m1;
          end else begin
            visited_r[scan.col] <= 1'b1;
            if (cand_partner == '0) begin
              // Free column: the path is complete, commit the top frame now.
              partner_r[scan.col] <= cur_left_r;
              match_cnt_r         <= match_cnt_r + CNT_W'(1);
              wb_k_r              <= depth_m2[LIDX_W-1:0];
            end else begin
              // Descend into the left vertex that holds this column.
              cur_left_r <= cand_partner;
              cur_next_r <= '0;
              depth_r    <= depth_r + CNT_W'(1);
            end
          end
        end
        S_POPW: begin
          cur_left_r <= stk_rdata.left;
          cur_next_r <= stk_rdata.next;
        end
        S_WB: begin
          partner_r[stk_rdata.col] <= stk_rdata.left;
          if (wb_k_r != '0) begin
            wb_k_r <= wb_k_m1;
          end
        end
        S_NEXT: begin
          u_r    <= u_r + CNT_W'(1);
          oidx_r <= '0;
        end
        S_OUT: begin
          if (out_fire) begin
            oidx_r <= oidx_r + COL_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word for the current right vertex.
  assign out_is_last = ({1'b0, oidx_r} + CNT_W'(1)) == rc_r;
  assign out_tlast   = out_is_last;
  assign out_tdata   = {2'b00,
                        (out_is_last ? match_cnt_r : CNT_W'(0)),
                        partner_r[oidx_r],
                        oidx_r};

  `BMM_NEVER(a_depth_bound, clk, rst_n, depth_r > LEFT_MAX_C, "search stack overflow")
  `BMM_NEVER(a_one_side, clk, rst_n, in_tready && out_tvalid, "input and output open together")
  `BMM_ASSERT(a_scan_depth, clk, rst_n, (state_r == S_SCAN) |-> (depth_r != '0), "scan on empty stack")
  `BMM_ASSERT(a_total_bound, clk, rst_n, (state_r == S_OUT) |-> (match_cnt_r <= rc_r), "match count above right count")
  `BMM_ASSERT(a_wb_next, clk, rst_n, ((state_r == S_WB) && (wb_k_r == '0)) |=> (state_r == S_NEXT), "commit does not finish")

endmodule

`default_nettype wire
